// ----- rtl/core/dppi_pkg.sv -----
// Shared constants, stream widths and the sample power function.
`timescale 1ns / 1ps

package dppi_pkg;

    localparam int NUM_CHANNELS_DEF = 1024;
    localparam int NUM_POLS_DEF     = 2;
    localparam int MAX_PACKETS_DEF  = 65536;

    localparam int SAMPLE_W  = 8;
    localparam int CHANNEL_W = 10;
    localparam int POWER_W   = 32;
    localparam int COUNT_W   = 17;
    localparam int SQ_W      = 8;

    // Input: tdata = {channel, sample_byte}, tuser = {first_packet, packet_invalid, pol}
    localparam int IN_TDATA_W = 24;
    localparam int IN_TUSER_W = 3;
    // Output: tdata = {valid_packets, power_sum, out_channel}, tuser = out_pol
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_TUSER_W = 1;

    // Power of one 4-bit complex sample, each part offset binary with bias 8.
    function automatic logic [SQ_W-1:0] f_sample_power(input logic [SAMPLE_W-1:0] b);
        logic signed [3:0] re;
        logic signed [3:0] im;
        logic signed [7:0] re_sq;
        logic signed [7:0] im_sq;
        re    = {~b[7], b[6:4]};
        im    = {~b[3], b[2:0]};
        re_sq = 8'(re) * 8'(re);
        im_sq = 8'(im) * 8'(im);
        return SQ_W'(unsigned'(re_sq)) + SQ_W'(unsigned'(im_sq));
    endfunction

endpackage

// ----- rtl/core/dppi_acc_ram.sv -----
// Accumulator memory: one write port, one registered read port.
`timescale 1ns / 1ps

module dppi_acc_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [dppi_pkg::POWER_W-1:0]  o_rd_data,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [dppi_pkg::POWER_W-1:0]  i_wr_data
);
    import dppi_pkg::*;

    logic [POWER_W-1:0] r_mem [DEPTH];
    logic [POWER_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/dual_pol_power_integrator.sv -----
// Top level: per (polarization, channel) power integrator over 4-bit complex samples.
`timescale 1ns / 1ps

// Accepts one sample transaction per clock while the output side keeps up. An
// item is read from the accumulator RAM at acceptance into stage 1. When
// stage 1 fires, the sum is written back and, on a last packet, loaded into
// the output register, two register stages in all; a last-packet item waits
// in stage 1 while the output register is full. The write of the previous
// item is forwarded into the add so back-to-back samples of the same channel
// accumulate correctly. i_m_tready reaches o_s_tready through logic only.
// While a result waits and the receiver holds off, input keeps flowing until a
// last-packet item reaches the add stage, then stalls until the result leaves.
// Items whose polarization or channel lies outside the configured range are
// dropped. Accumulators and counts are undefined until a first packet writes
// them; there is no clearing pass.
module dual_pol_power_integrator #(
    parameter int NUM_CHANNELS = dppi_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_POLS     = dppi_pkg::NUM_POLS_DEF,
    parameter int MAX_PACKETS  = dppi_pkg::MAX_PACKETS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [7:0] sample_byte, [17:8] channel, [23:18] zero
    input  logic [dppi_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // [0] pol, [1] packet_invalid, [2] first_packet
    input  logic [dppi_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                             i_s_tlast,   // last_packet
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [9:0] out_channel, [41:10] power_sum, [58:42] valid_packets, [63:59] zero
    output logic [dppi_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // [0] out_pol
    output logic [dppi_pkg::OUT_TUSER_W-1:0] o_m_tuser
);
    import dppi_pkg::*;

    localparam int DEPTH = NUM_POLS * NUM_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = (NUM_POLS > 1) ? $clog2(NUM_POLS) : 1;
    localparam int CW    = $clog2(MAX_PACKETS + 1);

    // input decode
    logic [SAMPLE_W-1:0]  in_sample;
    logic [CHANNEL_W-1:0] in_channel;
    logic                 in_pol;
    logic                 in_accept;
    logic                 in_range;
    logic [AW-1:0]        in_addr;

    // stage 1
    logic                 r_s1_valid;
    logic [AW-1:0]        r_s1_addr;
    logic [SQ_W-1:0]      r_s1_power;
    logic                 r_s1_pol;
    logic [CHANNEL_W-1:0] r_s1_channel;
    logic                 r_s1_invalid;
    logic                 r_s1_first;
    logic                 r_s1_last;
    logic [POWER_W-1:0]   rd_data;
    logic                 s1_fire;
    logic                 out_free;
    logic [POWER_W-1:0]   acc_base;
    logic [POWER_W-1:0]   acc_sum;
    logic [PW-1:0]        s1_pol_idx;
    logic                 s1_chan0;
    logic [CW-1:0]        cnt_base;
    logic [CW-1:0]        cnt_new;
    logic [CW-1:0]        cnt_out;
    logic [CW+COUNT_W-1:0] cnt_wide;

    // forwarding of the last write
    logic                 r_wr_valid;
    logic [AW-1:0]        r_wr_addr;
    logic [POWER_W-1:0]   r_wr_data;

    logic [CW-1:0]        r_cnt [NUM_POLS];

    // output register
    logic                 r_out_valid;
    logic                 r_out_pol;
    logic [CHANNEL_W-1:0] r_out_channel;
    logic [POWER_W-1:0]   r_out_sum;
    logic [COUNT_W-1:0]   r_out_count;

    assign in_sample  = i_s_tdata[SAMPLE_W-1:0];
    assign in_channel = i_s_tdata[SAMPLE_W+CHANNEL_W-1:SAMPLE_W];
    assign in_pol     = i_s_tuser[0];
    assign in_range   = (32'(in_pol) < 32'(NUM_POLS)) && (32'(in_channel) < 32'(NUM_CHANNELS));
    assign in_addr    = AW'(32'(in_pol) * 32'(NUM_CHANNELS) + 32'(in_channel));

    assign out_free   = !r_out_valid || i_m_tready;
    assign s1_fire    = r_s1_valid && (!r_s1_last || out_free);
    assign o_s_tready = !r_s1_valid || s1_fire;
    assign in_accept  = i_s_tvalid && o_s_tready;

    dppi_acc_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_acc_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (acc_sum)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= in_range;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_wr_valid <= 1'b1;
            end
            if (s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_addr    <= in_addr;
            r_s1_power   <= f_sample_power(in_sample);
            r_s1_pol     <= in_pol;
            r_s1_channel <= in_channel;
            r_s1_invalid <= i_s_tuser[1];
            r_s1_first   <= i_s_tuser[2];
            r_s1_last    <= i_s_tlast;
        end
    end

    // add the sample power, taking the previous write when it hits the same entry; a first packet restarts the sum
    always_comb begin
        acc_base = (r_wr_valid && (r_wr_addr == r_s1_addr)) ? r_wr_data : rd_data;
        if (r_s1_first) begin
            acc_sum = r_s1_invalid ? '0 : POWER_W'(r_s1_power);
        end else begin
            acc_sum = acc_base + (r_s1_invalid ? '0 : POWER_W'(r_s1_power));
        end
    end

    // valid packet count, advanced on channel 0 and saturating
    always_comb begin
        s1_pol_idx = PW'(r_s1_pol);
        s1_chan0   = (r_s1_channel == '0);
        cnt_base   = r_s1_first ? '0 : r_cnt[s1_pol_idx];
        cnt_new    = cnt_base;
        if (!r_s1_invalid && (32'(cnt_base) < 32'(MAX_PACKETS))) begin
            cnt_new = cnt_base + CW'(1);
        end
        cnt_out  = s1_chan0 ? cnt_new : r_cnt[s1_pol_idx];
        cnt_wide = {{COUNT_W{1'b0}}, cnt_out};
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_wr_addr <= r_s1_addr;
            r_wr_data <= acc_sum;
            if (s1_chan0) begin
                r_cnt[s1_pol_idx] <= cnt_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_last) begin
            r_out_pol     <= r_s1_pol;
            r_out_channel <= r_s1_channel;
            r_out_sum     <= acc_sum;
            r_out_count   <= cnt_wide[COUNT_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - COUNT_W - POWER_W - CHANNEL_W){1'b0}},
                         r_out_count, r_out_sum, r_out_channel};
    assign o_m_tuser  = r_out_pol;

endmodule

// ----- tb/tb_top.sv -----
// Testbench for the dual-polarization power integrator: directed, random and stress tests.
`timescale 1ns / 1ps

module tb_top;

    import dppi_pkg::*;

    localparam int NCHAN      = NUM_CHANNELS_DEF;
    localparam int NPOL       = NUM_POLS_DEF;
    localparam int PKT_LIMIT  = MAX_PACKETS_DEF;
    localparam int SLOTS      = NCHAN * NPOL;

    typedef struct packed {
        logic [SAMPLE_W-1:0]  sample_byte;
        logic                 pol;
        logic [CHANNEL_W-1:0] channel;
        logic                 invalid;
        logic                 is_first;
        logic                 is_last;
    } t_sample;

    typedef struct packed {
        logic                 pol;
        logic [CHANNEL_W-1:0] channel;
        logic [POWER_W-1:0]   power_sum;
        logic [COUNT_W-1:0]   valid_packets;
    } t_power_result;

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_tuser  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    // Integrator state as the design should hold it
    logic [POWER_W-1:0] power_acc [SLOTS];
    bit                 slot_written [SLOTS];
    int unsigned        pkt_count [NPOL];
    bit                 count_written [NPOL];

    t_power_result expected_powers [$];

    int n_samples;
    int n_results;
    int n_errors;
    bit idling;
    int rx_hold_cycles;

    dual_pol_power_integrator dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int idle_len();
        int r;
        if (!idling) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_sample make_sample(input int pol, input int ch, input int sbyte,
                                            input bit inv, input bit first, input bit last);
        t_sample s;
        s.pol         = pol[0];
        s.channel     = ch[CHANNEL_W-1:0];
        s.sample_byte = sbyte[SAMPLE_W-1:0];
        s.invalid     = inv;
        s.is_first    = first;
        s.is_last     = last;
        return s;
    endfunction

    // Update the integrator state with one sample; return 1 when it emits a result
    function automatic bit integrate_sample(input t_sample s, output t_power_result r);
        int          slot;
        int          re;
        int          im;
        logic [31:0] p;
        int unsigned cnt;
        slot = int'(s.pol) * NCHAN + int'(s.channel);
        re   = int'(s.sample_byte[7:4]) - 8;
        im   = int'(s.sample_byte[3:0]) - 8;
        p    = s.invalid ? 32'd0 : 32'(re * re + im * im);
        if (s.is_first) power_acc[slot] = p;
        else power_acc[slot] = power_acc[slot] + p;
        slot_written[slot] = 1'b1;
        if (s.channel == '0) begin
            cnt = s.is_first ? 0 : pkt_count[s.pol];
            if (!s.invalid && cnt < PKT_LIMIT) cnt++;
            pkt_count[s.pol]     = cnt;
            count_written[s.pol] = 1'b1;
        end
        r.pol           = s.pol;
        r.channel       = s.channel;
        r.power_sum     = power_acc[slot];
        r.valid_packets = pkt_count[s.pol][COUNT_W-1:0];
        return s.is_last;
    endfunction

    // Offer one sample and hold it until the transaction completes; valid stays high after
    task automatic push_sample(input t_sample s);
        int            gap;
        t_power_result r;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - CHANNEL_W - SAMPLE_W){1'b0}}, s.channel, s.sample_byte};
        s_tuser  <= {s.is_first, s.invalid, s.pol};
        s_tlast  <= s.is_last;
        do @(posedge clk); while (s_tready !== 1'b1);
        n_samples++;
        if (integrate_sample(s, r)) expected_powers.push_back(r);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20) stall_left = idle_len();
            end
        end
    end

    task automatic field_check(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk) begin : check_results
        t_power_result want;
        if (rst_n && m_tvalid === 1'b1 && m_tready) begin
            if (expected_powers.size() == 0) begin
                $error("unexpected result transaction: channel %0d power %0d",
                       m_tdata[CHANNEL_W-1:0], m_tdata[CHANNEL_W +: POWER_W]);
                n_errors++;
            end else begin
                want = expected_powers.pop_front();
                field_check("out_pol", 32'(want.pol), 32'(m_tuser[0]));
                field_check("out_channel", 32'(want.channel), 32'(m_tdata[CHANNEL_W-1:0]));
                field_check("power_sum", want.power_sum, m_tdata[CHANNEL_W +: POWER_W]);
                field_check("valid_packets", 32'(want.valid_packets),
                            32'(m_tdata[CHANNEL_W + POWER_W +: COUNT_W]));
            end
            n_results++;
        end
    end

    // Byte extremes, channel extremes, clears, first+last, invalid packets, same-channel runs
    task automatic test_directed();
        idling = 1'b1;
        push_sample(make_sample(0, 0,    8'h00, 0, 1, 1));
        push_sample(make_sample(0, 1023, 8'hFF, 0, 1, 1));
        push_sample(make_sample(0, 0,    8'h88, 0, 0, 1));
        push_sample(make_sample(0, 1023, 8'h0F, 1, 0, 1));
        push_sample(make_sample(1, 0,    8'hF0, 1, 1, 1));
        push_sample(make_sample(1, 0,    8'h80, 0, 0, 0));
        push_sample(make_sample(1, 0,    8'h08, 0, 0, 1));
        push_sample(make_sample(1, 0,    8'h77, 0, 0, 1));
        push_sample(make_sample(1, 1023, 8'hFF, 1, 1, 1));
        push_sample(make_sample(1, 1023, 8'h00, 0, 0, 1));
        push_sample(make_sample(0, 0,    8'h00, 1, 0, 1));
        push_sample(make_sample(0, 0,    8'h5A, 0, 1, 0));
        push_sample(make_sample(0, 0,    8'hA5, 0, 0, 1));
        push_sample(make_sample(0, 682,  8'h3C, 0, 1, 1));
        push_sample(make_sample(0, 341,  8'hC3, 0, 1, 1));
        push_sample(make_sample(1, 682,  8'h69, 0, 1, 0));
        push_sample(make_sample(1, 682,  8'h96, 1, 0, 1));
    endtask

    // Hold the receiver off while results keep coming so the input stalls
    task automatic test_output_stall();
        idling = 1'b0;
        for (int k = 0; k < 64; k++)
            push_sample(make_sample(1, k * 16, $urandom_range(0, 255), 0, 1, 1));
        rx_hold_cycles = 300;
        for (int k = 0; k < 64; k++)
            push_sample(make_sample(1, k * 16, $urandom_range(0, 255),
                                    1'($urandom_range(0, 1)), 0, 1));
    endtask

    // Integration windows with random content, plus truncated windows and stray samples
    task automatic test_random_windows();
        int      target;
        int      pol;
        int      ch;
        int      nch;
        int      npk;
        int      slot;
        bit      truncate;
        bit      pkt_inv;
        bit      first;
        bit      last;
        int      chans [$];
        target = n_samples + 600;
        while (n_samples < target) begin
            idling = ((n_samples / 120) % 3) != 2;
            if ($urandom_range(0, 99) < 80) begin
                pol = $urandom_range(0, 1);
                nch = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
                chans.delete();
                for (int i = 0; i < nch; i++) chans.push_back($urandom_range(0, NCHAN - 1));
                // channel 0 first so the packet count exists before any result reads it
                if (!count_written[pol] || $urandom_range(0, 3) != 0) chans[0] = 0;
                npk      = $urandom_range(1, 5);
                truncate = ($urandom_range(0, 7) == 0);
                for (int k = 0; k < npk; k++) begin
                    pkt_inv = ($urandom_range(0, 4) == 0);
                    foreach (chans[i])
                        push_sample(make_sample(pol, chans[i], $urandom_range(0, 255), pkt_inv,
                                                k == 0, k == npk - 1 && !truncate));
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    pol   = $urandom_range(0, 1);
                    ch    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, NCHAN - 1);
                    slot  = pol * NCHAN + ch;
                    first = !slot_written[slot] || ($urandom_range(0, 3) == 0);
                    last  = (count_written[pol] || ch == 0) && $urandom_range(0, 1);
                    push_sample(make_sample(pol, ch, $urandom_range(0, 255),
                                            1'($urandom_range(0, 1)), first, last));
                end
            end
        end
    endtask

    // Run one long window on a single channel, reporting now and then
    task automatic test_long_window();
        int total;
        bit last;
        idling = 1'b0;
        total  = 60;
        push_sample(make_sample(0, 0, $urandom_range(0, 255), 0, 1, 0));
        for (int i = 1; i <= total; i++) begin
            last = (i % 16 == 0) || (i >= total - 6);
            push_sample(make_sample(0, 0, $urandom_range(0, 255), i % 7 == 3, 0, last));
        end
    endtask

    initial begin
        n_samples      = 0;
        n_results      = 0;
        n_errors       = 0;
        rx_hold_cycles = 0;
        idling         = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_output_stall();
        test_random_windows();
        test_long_window();
        s_tvalid <= 1'b0;
        while (expected_powers.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Integrated %0d samples and checked %0d results, including output hold-off",
                 n_samples, n_results);
        $display("and one long window whose packet count climbs on a single channel.");
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
